>>> rtl/stq_pkg.sv
// Package for the sorted timer queue: field widths, operation and result codes,
// sequencer states and parameter defaults. No dependencies.
package stq_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int TIME_BITS_DEF  = 48;

    localparam int OP_W    = 2;
    localparam int ID_W    = 4;
    localparam int TMO_W   = 32;
    localparam int NOW_W   = 48;
    localparam int KIND_W  = 2;
    localparam int DELAY_W = 32;

    localparam logic [OP_W-1:0] OP_ARM    = 2'd0;
    localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
    localparam logic [OP_W-1:0] OP_SCHED  = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELAY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DONE    = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RM_RD,
        ST_RM_CHK,
        ST_INS_START,
        ST_INS_RD,
        ST_INS_EXP,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_SCH_RD,
        ST_SCH_EXP,
        ST_SCH_CMP,
        ST_SCH_EMIT,
        ST_SH_RD,
        ST_SH_WR,
        ST_DONE
    } state_t;

endpackage

>>> rtl/sorted_timer_queue.sv
// Sorted timer queue: a sequencer over an order memory and an expiry memory.
// Arm and cancel rewrite each queued entry but the slot to remove it; arm then walks
// from the tail, shifting later entries up, and puts the slot in place. Schedule emits
// each expired slot from the head, stalling while the output is held, then copies the
// entries behind the first that stays down to compact the order memory. One transaction
// is in work at a time. Synchronous active-low reset empties the queue at once.
module sorted_timer_queue #(
    parameter int NUM_TIMERS = stq_pkg::NUM_TIMERS_DEF,
    parameter int TIME_BITS  = stq_pkg::TIME_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [stq_pkg::OP_W-1:0]     s_operation,
    input  logic [stq_pkg::ID_W-1:0]     s_timer_id,
    input  logic [stq_pkg::TMO_W-1:0]    s_timeout_ms,
    input  logic [stq_pkg::NOW_W-1:0]    s_now_ms,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [stq_pkg::KIND_W-1:0]   m_result_kind,
    output logic [stq_pkg::ID_W-1:0]     m_expired_id,
    output logic [stq_pkg::DELAY_W-1:0]  m_delay_ms,
    output logic                         m_last
);
    import stq_pkg::*;

    localparam int IW = $clog2(NUM_TIMERS);
    localparam int PW = $clog2(NUM_TIMERS + 1);

    state_t state_reg, state_next;

    logic [OP_W-1:0]       op_reg, op_next;
    logic [IW-1:0]         slot_reg, slot_next;
    logic [TIME_BITS-1:0]  now_reg, now_next;
    logic [TIME_BITS-1:0]  exp_reg, exp_next;
    logic [TIME_BITS-1:0]  first_reg, first_next;
    logic [PW-1:0]         idx_reg, idx_next;
    logic [PW-1:0]         wr_reg, wr_next;
    logic [PW-1:0]         len_reg, len_next;
    logic [NUM_TIMERS-1:0] armed_reg, armed_next;
    logic [KIND_W-1:0]     kind_reg, kind_next;

    logic                  m_valid_reg, m_valid_next;
    logic [KIND_W-1:0]     m_kind_reg, m_kind_next;
    logic [ID_W-1:0]       m_id_reg, m_id_next;
    logic [DELAY_W-1:0]    m_delay_reg, m_delay_next;
    logic                  m_last_reg, m_last_next;

    logic [IW-1:0]         ord_mem [NUM_TIMERS];
    logic [TIME_BITS-1:0]  exp_mem [NUM_TIMERS];
    logic [IW-1:0]         ord_rdata_reg;
    logic [TIME_BITS-1:0]  exp_rdata_reg;
    logic                  ord_we, ord_re, exp_we, exp_re;
    logic [IW-1:0]         ord_waddr, ord_wdata, ord_raddr, exp_raddr;

    logic                  accept, out_free, in_range, last_pos;
    logic [IW-1:0]         slot_in;
    logic [TIME_BITS-1:0]  now_in, exp_in, diff;
    logic [TIME_BITS:0]    sum;
    logic [TMO_W-1:0]      tmo1;
    logic [DELAY_W-1:0]    delay_sat;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign in_range = 32'(s_timer_id) < NUM_TIMERS;
    assign slot_in  = IW'(s_timer_id);
    assign now_in   = TIME_BITS'(s_now_ms);
    assign tmo1     = (s_timeout_ms == '0) ? TMO_W'(1) : s_timeout_ms;
    assign sum      = {1'b0, now_in} + (TIME_BITS + 1)'(tmo1);
    assign exp_in   = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
    assign last_pos = (idx_reg + PW'(1)) == len_reg;
    assign diff     = first_reg - now_reg;
    assign delay_sat = (|diff[TIME_BITS-1:DELAY_W]) ? '1 : diff[DELAY_W-1:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_operation)
                        OP_ARM:    state_next = !in_range ? ST_DONE :
                                   (armed_reg[slot_in] ? ST_RM_RD : ST_INS_START);
                        OP_CANCEL: state_next = (in_range && armed_reg[slot_in]) ?
                                   ST_RM_RD : ST_DONE;
                        OP_SCHED:  state_next = ST_SCH_RD;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_RM_RD:  state_next = ST_RM_CHK;
            ST_RM_CHK: begin
                if (last_pos) begin
                    state_next = (op_reg == OP_ARM) ? ST_INS_START : ST_DONE;
                end else begin
                    state_next = ST_RM_RD;
                end
            end
            ST_INS_START: begin
                if (32'(len_reg) >= NUM_TIMERS || len_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_INS_RD;
                end
            end
            ST_INS_RD:  state_next = ST_INS_EXP;
            ST_INS_EXP: state_next = ST_INS_CMP;
            ST_INS_CMP: begin
                if (exp_reg < exp_rdata_reg && idx_reg != '0) begin
                    state_next = ST_INS_RD;
                end else begin
                    state_next = ST_INS_PUT;
                end
            end
            ST_INS_PUT: state_next = ST_DONE;
            ST_SCH_RD:  state_next = (idx_reg == len_reg) ? ST_DONE : ST_SCH_EXP;
            ST_SCH_EXP: state_next = ST_SCH_CMP;
            ST_SCH_CMP: begin
                if (now_reg >= exp_rdata_reg) begin
                    state_next = ST_SCH_EMIT;
                end else begin
                    state_next = (idx_reg == '0) ? ST_DONE : ST_SH_RD;
                end
            end
            ST_SCH_EMIT: if (out_free) state_next = ST_SCH_RD;
            ST_SH_RD:    state_next = ST_SH_WR;
            ST_SH_WR:    state_next = last_pos ? ST_DONE : ST_SH_RD;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        op_next = op_reg;
        slot_next = slot_reg;
        now_next = now_reg;
        exp_next = exp_reg;
        first_next = first_reg;
        idx_next = idx_reg;
        wr_next = wr_reg;
        len_next = len_reg;
        armed_next = armed_reg;
        kind_next = kind_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next = m_kind_reg;
        m_id_next = m_id_reg;
        m_delay_next = m_delay_reg;
        m_last_next = m_last_reg;
        ord_we = 1'b0;
        ord_waddr = '0;
        ord_wdata = '0;
        ord_re = 1'b0;
        ord_raddr = idx_reg[IW-1:0];
        exp_we = 1'b0;
        exp_re = 1'b0;
        exp_raddr = ord_rdata_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next = s_operation;
                    slot_next = slot_in;
                    now_next = now_in;
                    exp_next = exp_in;
                    idx_next = '0;
                    wr_next = '0;
                    kind_next = KIND_DONE;
                    exp_we = (s_operation == OP_ARM) && in_range;
                    if (s_operation == OP_CLEAR) begin
                        armed_next = '0;
                        len_next = '0;
                    end
                end
            end
            ST_RM_RD: ord_re = 1'b1;
            ST_RM_CHK: begin
                if (ord_rdata_reg != slot_reg) begin
                    ord_we = 1'b1;
                    ord_waddr = wr_reg[IW-1:0];
                    ord_wdata = ord_rdata_reg;
                    wr_next = wr_reg + PW'(1);
                end
                idx_next = idx_reg + PW'(1);
                if (last_pos) begin
                    len_next = len_reg - PW'(1);
                    armed_next[slot_reg] = 1'b0;
                end
            end
            ST_INS_START: begin
                if (len_reg == '0) begin
                    ord_we = 1'b1;
                    ord_waddr = '0;
                    ord_wdata = slot_reg;
                    len_next = PW'(1);
                    armed_next[slot_reg] = 1'b1;
                end
                idx_next = len_reg - PW'(1);
            end
            ST_INS_RD:  ord_re = 1'b1;
            ST_INS_EXP: exp_re = 1'b1;
            ST_INS_CMP: begin
                if (exp_reg < exp_rdata_reg) begin
                    ord_we = 1'b1;
                    ord_waddr = IW'(idx_reg + PW'(1));
                    ord_wdata = ord_rdata_reg;
                    wr_next = idx_reg;
                    idx_next = idx_reg - PW'(1);
                end else begin
                    wr_next = idx_reg + PW'(1);
                end
            end
            ST_INS_PUT: begin
                ord_we = 1'b1;
                ord_waddr = wr_reg[IW-1:0];
                ord_wdata = slot_reg;
                len_next = len_reg + PW'(1);
                armed_next[slot_reg] = 1'b1;
            end
            ST_SCH_RD: begin
                if (idx_reg == len_reg) begin
                    len_next = '0;
                    kind_next = KIND_EMPTY;
                end else begin
                    ord_re = 1'b1;
                end
            end
            ST_SCH_EXP: exp_re = 1'b1;
            ST_SCH_CMP: begin
                if (now_reg < exp_rdata_reg) begin
                    first_next = exp_rdata_reg;
                    kind_next = KIND_DELAY;
                    wr_next = '0;
                end
            end
            ST_SCH_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next = KIND_EXPIRED;
                    m_id_next = ID_W'(ord_rdata_reg);
                    m_delay_next = '0;
                    m_last_next = 1'b0;
                    armed_next[ord_rdata_reg] = 1'b0;
                    idx_next = idx_reg + PW'(1);
                end
            end
            ST_SH_RD: ord_re = 1'b1;
            ST_SH_WR: begin
                ord_we = 1'b1;
                ord_waddr = wr_reg[IW-1:0];
                ord_wdata = ord_rdata_reg;
                idx_next = idx_reg + PW'(1);
                wr_next = wr_reg + PW'(1);
                if (last_pos) begin
                    len_next = wr_reg + PW'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next = kind_reg;
                    m_id_next = '0;
                    m_delay_next = (kind_reg == KIND_DELAY) ? delay_sat : '0;
                    m_last_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ord_we) begin
            ord_mem[ord_waddr] <= ord_wdata;
        end
        if (ord_re) begin
            ord_rdata_reg <= ord_mem[ord_raddr];
        end
        if (exp_we) begin
            exp_mem[slot_in] <= exp_in;
        end
        if (exp_re) begin
            exp_rdata_reg <= exp_mem[exp_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            len_reg <= '0;
            armed_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            len_reg <= len_next;
            armed_reg <= armed_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg <= op_next;
        slot_reg <= slot_next;
        now_reg <= now_next;
        exp_reg <= exp_next;
        first_reg <= first_next;
        idx_reg <= idx_next;
        wr_reg <= wr_next;
        kind_reg <= kind_next;
        m_kind_reg <= m_kind_next;
        m_id_reg <= m_id_next;
        m_delay_reg <= m_delay_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid = m_valid_reg;
    assign m_result_kind = m_kind_reg;
    assign m_expired_id = m_id_reg;
    assign m_delay_ms = m_delay_reg;
    assign m_last = m_last_reg;

endmodule

>>> rtl/stq_checker.sv
// Port-level checker for the sorted timer queue, attached by bind.
// Depends on stq_pkg for the result codes.
module stq_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [stq_pkg::KIND_W-1:0]   m_result_kind,
    input logic [stq_pkg::ID_W-1:0]     m_expired_id,
    input logic [stq_pkg::DELAY_W-1:0]  m_delay_ms,
    input logic                         m_last
);
    import stq_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_kind) && $stable(m_last))
        else $error("Result changed while stalled.");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Input accepted while a transaction was in work.");

    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_result_kind != KIND_EXPIRED)))
        else $error("Last flag does not match result kind.");

    a_id_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind != KIND_EXPIRED |-> m_expired_id == '0)
        else $error("Expired id set on a non-expiry result.");

    a_delay: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_result_kind == KIND_DELAY) == (m_delay_ms != '0)))
        else $error("Delay field inconsistent with result kind.");

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_result_kind(m_result_kind),
    .m_expired_id(m_expired_id), .m_delay_ms(m_delay_ms), .m_last(m_last)
);
